// ===== rtl/yee2d_pkg.sv =====
// Package for the 2D Yee magnetic field update core.
// Holds default sizes, register widths and register indexes; no dependencies.
package yee2d_pkg;

   localparam int MAX_COLS_DEF   = 1024;
   localparam int FIELD_BITS_DEF = 32;

   localparam int ROWS_W     = 16;
   localparam int COLS_W     = 11;
   localparam int COEF_W     = 17;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 17;

   localparam logic [CSR_IDX_W-1:0] CSR_ROWS_DUAL = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS_DUAL = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_X    = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_Y    = 2'd3;

endpackage

// ===== rtl/yee2d_if.sv =====
// Stream interfaces for request and response words of the Yee update core.
// Depends on yee2d_pkg for the default field width.
interface yee2d_req_if #(parameter int FIELD_BITS = yee2d_pkg::FIELD_BITS_DEF);
   logic                         valid;
   logic                         ready;
   logic signed [FIELD_BITS-1:0] e_x;
   logic signed [FIELD_BITS-1:0] e_y;
   logic signed [FIELD_BITS-1:0] e_z;
   logic signed [FIELD_BITS-1:0] b_x_old;
   logic signed [FIELD_BITS-1:0] b_y_old;
   logic signed [FIELD_BITS-1:0] b_z_old;

   modport source (output valid, e_x, e_y, e_z, b_x_old, b_y_old, b_z_old, input ready);
   modport sink   (input valid, e_x, e_y, e_z, b_x_old, b_y_old, b_z_old, output ready);
endinterface

interface yee2d_rsp_if #(parameter int FIELD_BITS = yee2d_pkg::FIELD_BITS_DEF);
   logic                         valid;
   logic                         ready;
   logic signed [FIELD_BITS-1:0] b_x_new;
   logic signed [FIELD_BITS-1:0] b_y_new;
   logic signed [FIELD_BITS-1:0] b_z_new;
   logic                         frame_end;

   modport source (output valid, b_x_new, b_y_new, b_z_new, frame_end, input ready);
   modport sink   (input valid, b_x_new, b_y_new, b_z_new, frame_end, output ready);
endinterface

// ===== rtl/yee2d_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module yee2d_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/yee_2d_magnetic_field_update_core.sv =====
// Top level of the 2D Yee FDTD magnetic field update core.
// Uses yee2d_pkg, yee2d_req_if / yee2d_rsp_if and yee2d_ram (row store).
// Throughput: one word per cycle when rsp.ready does not stall, set by the row RAM's
// single read and write port. A taken word passes stages 1-3 and the output register.
// Reset (synchronous): registers to defaults, grid position, previous-point and valid
// state cleared; row RAM contents are not cleared and are written as the first row passes.
module yee_2d_magnetic_field_update_core #(
   parameter int MAX_COLS   = yee2d_pkg::MAX_COLS_DEF,
   parameter int FIELD_BITS = yee2d_pkg::FIELD_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   yee2d_req_if.sink                           req,
   yee2d_rsp_if.source                         rsp,
   input  logic                                csr_we,
   input  logic [yee2d_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [yee2d_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int FB       = FIELD_BITS;
   localparam int DW       = FB + 1;          // difference width
   localparam int PW       = FB + 19;         // full product width
   localparam int QW       = FB + 3;          // product after dropping fraction
   localparam int SW       = FB + 4;          // sum width before saturation
   localparam int COL_BITS = $clog2(MAX_COLS);
   localparam int CNT_W    = $clog2(MAX_COLS + 1);
   localparam int CLAMP_W  = (CNT_W > yee2d_pkg::COLS_W) ? CNT_W : yee2d_pkg::COLS_W;
   localparam int RW       = yee2d_pkg::ROWS_W;
   localparam int CW       = yee2d_pkg::COEF_W;

   typedef struct packed {
      logic upd_x;
      logic upd_y;
      logic upd_z;
      logic last;
   } flags_type;

   function automatic logic signed [FB-1:0] sat_f(input logic signed [SW-1:0] v);
      logic signed [FB-1:0] r;
      if (!v[SW-1] && (|v[SW-2:FB-1])) begin
         r = {1'b0, {(FB-1){1'b1}}};
      end else if (v[SW-1] && !(&v[SW-2:FB-1])) begin
         r = {1'b1, {(FB-1){1'b0}}};
      end else begin
         r = v[FB-1:0];
      end
      return r;
   endfunction

   // ---------------- configuration ----------------
   logic [RW-1:0]    rows_ff, rows_in;
   logic [CNT_W-1:0] cols_ff, cols_in;
   logic [CW-1:0]    coef_x_ff, coef_y_ff;
   logic [CLAMP_W-1:0] cols_raw;

   always_comb begin
      rows_in  = csr_wdata[RW-1:0];
      if (rows_in < RW'(2)) begin
         rows_in = RW'(2);
      end
      cols_raw = CLAMP_W'(csr_wdata[yee2d_pkg::COLS_W-1:0]);
      if (cols_raw < CLAMP_W'(2)) begin
         cols_raw = CLAMP_W'(2);
      end else if (cols_raw > CLAMP_W'(MAX_COLS)) begin
         cols_raw = CLAMP_W'(MAX_COLS);
      end
      cols_in = cols_raw[CNT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff   <= RW'(2);
         cols_ff   <= CNT_W'(2);
         coef_x_ff <= '0;
         coef_y_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            yee2d_pkg::CSR_ROWS_DUAL: rows_ff   <= rows_in;
            yee2d_pkg::CSR_COLS_DUAL: cols_ff   <= cols_in;
            yee2d_pkg::CSR_COEF_X:    coef_x_ff <= csr_wdata[CW-1:0];
            yee2d_pkg::CSR_COEF_Y:    coef_y_ff <= csr_wdata[CW-1:0];
         endcase
      end
   end

   // ---------------- handshake ----------------
   logic out_valid_ff, s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic advance, accept;

   assign advance   = !out_valid_ff || rsp.ready;
   assign req.ready = advance && !reset;
   assign accept    = req.valid && req.ready;

   // ---------------- position (stage 0) ----------------
   logic [RW-1:0]       row_ff, row_in;
   logic [COL_BITS-1:0] col_ff, col_in;
   logic [RW:0]         row_t;
   logic [RW-1:0]       pos_x, rows_m1;
   logic [COL_BITS-1:0] pos_y;
   logic [CNT_W-1:0]    cols_m1;
   logic                col_wrap, x_last, y_last;
   flags_type           flags0;

   always_comb begin
      rows_m1  = rows_ff - RW'(1);
      cols_m1  = cols_ff - CNT_W'(1);
      // lazy wrap covers a position left beyond a bound that shrank
      col_wrap = CNT_W'(col_ff) >= cols_ff;
      row_t    = col_wrap ? ((RW+1)'(row_ff) + (RW+1)'(1)) : (RW+1)'(row_ff);
      pos_x    = (row_t >= (RW+1)'(rows_ff)) ? '0 : row_t[RW-1:0];
      pos_y    = col_wrap ? '0 : col_ff;
      x_last   = pos_x == rows_m1;
      y_last   = CNT_W'(pos_y) == cols_m1;

      flags0.upd_x = !x_last && (pos_y != '0) && !y_last;
      flags0.upd_y = (pos_x != '0) && !x_last && !y_last;
      flags0.upd_z = (pos_x != '0) && !x_last && (pos_y != '0) && !y_last;
      flags0.last  = x_last && y_last;

      if (y_last) begin
         col_in = '0;
         row_in = x_last ? '0 : pos_x + RW'(1);
      end else begin
         col_in = pos_y + COL_BITS'(1);
         row_in = pos_x;
      end
   end

   logic signed [FB-1:0] ez_prev_ff, ex_prev_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff     <= '0;
         col_ff     <= '0;
         ez_prev_ff <= '0;
         ex_prev_ff <= '0;
      end else if (accept) begin
         row_ff     <= row_in;
         col_ff     <= col_in;
         ez_prev_ff <= req.e_z;
         ex_prev_ff <= req.e_x;
      end
   end

   // ---------------- stage 1: row RAM read in flight ----------------
   logic signed [FB-1:0] s1_ez_ff, s1_ey_ff, s1_bx_ff, s1_by_ff, s1_bz_ff;
   logic signed [DW-1:0] s1_d_ex_ff, s1_d_ezx_ff;
   logic [COL_BITS-1:0]  s1_col_ff;
   flags_type            s1_flags_ff;
   logic [2*FB-1:0]      ram_rd_data;
   logic signed [FB-1:0] ez_up, ey_up;

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_ez_ff    <= req.e_z;
         s1_ey_ff    <= req.e_y;
         s1_bx_ff    <= req.b_x_old;
         s1_by_ff    <= req.b_y_old;
         s1_bz_ff    <= req.b_z_old;
         s1_d_ex_ff  <= DW'(req.e_x) - DW'(ex_prev_ff);
         s1_d_ezx_ff <= DW'(req.e_z) - DW'(ez_prev_ff);
         s1_col_ff   <= pos_y;
         s1_flags_ff <= flags0;
      end
   end

   // Write-back trails the read by one word; consecutive words hit different columns.
   yee2d_ram #(
      .WIDTH (2*FB),
      .DEPTH (MAX_COLS)
   ) u_row_ram (
      .clock   (clock),
      .wr_en   (advance && s1_valid_ff),
      .wr_addr (s1_col_ff),
      .wr_data ({s1_ez_ff, s1_ey_ff}),
      .rd_en   (accept),
      .rd_addr (pos_y),
      .rd_data (ram_rd_data)
   );

   assign ez_up = ram_rd_data[2*FB-1:FB];
   assign ey_up = ram_rd_data[FB-1:0];

   // ---------------- stage 2: differences ----------------
   logic signed [DW-1:0] s2_d_ex_ff, s2_d_ezx_ff, s2_d_ezu_ff, s2_d_eyu_ff;
   logic signed [FB-1:0] s2_bx_ff, s2_by_ff, s2_bz_ff;
   flags_type            s2_flags_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_d_ex_ff  <= s1_d_ex_ff;
         s2_d_ezx_ff <= s1_d_ezx_ff;
         s2_d_ezu_ff <= DW'(s1_ez_ff) - DW'(ez_up);
         s2_d_eyu_ff <= DW'(s1_ey_ff) - DW'(ey_up);
         s2_bx_ff    <= s1_bx_ff;
         s2_by_ff    <= s1_by_ff;
         s2_bz_ff    <= s1_bz_ff;
         s2_flags_ff <= s1_flags_ff;
      end
   end

   // ---------------- stage 3: products, floor of Q1.16 ----------------
   logic signed [CW:0]   cx_s, cy_s;
   logic signed [PW-1:0] prod_bx, prod_by, prod_bz1, prod_bz2;
   logic signed [QW-1:0] s3_p_bx_ff, s3_p_by_ff, s3_p_bz1_ff, s3_p_bz2_ff;
   logic signed [FB-1:0] s3_bx_ff, s3_by_ff, s3_bz_ff;
   flags_type            s3_flags_ff;

   assign cx_s     = $signed({1'b0, coef_x_ff});
   assign cy_s     = $signed({1'b0, coef_y_ff});
   assign prod_bx  = PW'(s2_d_ezx_ff) * PW'(cy_s);
   assign prod_by  = PW'(s2_d_ezu_ff) * PW'(cx_s);
   assign prod_bz1 = PW'(s2_d_ex_ff)  * PW'(cy_s);
   assign prod_bz2 = PW'(s2_d_eyu_ff) * PW'(cx_s);

   always_ff @(posedge clock) begin
      if (advance) begin
         s3_p_bx_ff  <= prod_bx[PW-1:16];
         s3_p_by_ff  <= prod_by[PW-1:16];
         s3_p_bz1_ff <= prod_bz1[PW-1:16];
         s3_p_bz2_ff <= prod_bz2[PW-1:16];
         s3_bx_ff    <= s2_bx_ff;
         s3_by_ff    <= s2_by_ff;
         s3_bz_ff    <= s2_bz_ff;
         s3_flags_ff <= s2_flags_ff;
      end
   end

   // ---------------- output register: sums and saturation ----------------
   logic signed [SW-1:0] sum_bx, sum_by, sum_bz;
   logic signed [FB-1:0] bx_out_ff, by_out_ff, bz_out_ff;
   logic                 last_out_ff;

   assign sum_bx = SW'(s3_bx_ff) - SW'(s3_p_bx_ff);
   assign sum_by = SW'(s3_by_ff) + SW'(s3_p_by_ff);
   assign sum_bz = SW'(s3_bz_ff) + SW'(s3_p_bz1_ff) - SW'(s3_p_bz2_ff);

   always_ff @(posedge clock) begin
      if (advance) begin
         bx_out_ff   <= s3_flags_ff.upd_x ? sat_f(sum_bx) : s3_bx_ff;
         by_out_ff   <= s3_flags_ff.upd_y ? sat_f(sum_by) : s3_by_ff;
         bz_out_ff   <= s3_flags_ff.upd_z ? sat_f(sum_bz) : s3_bz_ff;
         last_out_ff <= s3_flags_ff.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= accept;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         out_valid_ff <= s3_valid_ff;
      end
   end

   assign rsp.valid     = out_valid_ff;
   assign rsp.b_x_new   = bx_out_ff;
   assign rsp.b_y_new   = by_out_ff;
   assign rsp.b_z_new   = bz_out_ff;
   assign rsp.frame_end = last_out_ff;

endmodule

// ===== verif/tb.sv =====
// Testbench for yee_2d_magnetic_field_update_core: directed table, then random grids.
// Depends on yee2d_pkg and the yee2d_req_if / yee2d_rsp_if stream interfaces.
`timescale 1ns / 100ps

module tb;

   localparam logic signed [31:0] FMAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] FMIN = 32'sh8000_0000;

   typedef struct {
      logic signed [31:0] ex, ey, ez, bx, by, bz;
   } grid_word_type;

   typedef struct {
      logic signed [31:0] bx, by, bz;
      logic               fe;
   } b_word_type;

   typedef enum logic {PLAN_WORD, PLAN_CSR} plan_kind_type;

   typedef struct {
      plan_kind_type  kind;
      logic [1:0]     idx;
      int             data;
      grid_word_type  w;
      bit             typed;
      b_word_type     want;
   } plan_row_type;

   logic                             clock = 1'b0;
   logic                             reset;
   logic                             csr_we;
   logic [yee2d_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [yee2d_pkg::CSR_DATA_W-1:0] csr_wdata;

   yee2d_req_if req_ch ();
   yee2d_rsp_if rsp_ch ();

   yee_2d_magnetic_field_update_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #2 clock = ~clock;

   // shadow of the core: registers, line buffers, previous point, grid position
   logic [15:0]        cfg_rows = 16'd2;
   logic [10:0]        cfg_cols = 11'd2;
   logic [16:0]        cfg_cx   = '0;
   logic [16:0]        cfg_cy   = '0;
   logic signed [31:0] ez_line [yee2d_pkg::MAX_COLS_DEF];
   logic signed [31:0] ey_line [yee2d_pkg::MAX_COLS_DEF];
   logic signed [31:0] ez_last = '0;
   logic signed [31:0] ex_last = '0;
   int                 row_at = 0;
   int                 col_at = 0;
   int                 ring_hi = 0;   // line buffer entries 0..ring_hi-1 have been written

   b_word_type   b_due_q [$];
   plan_row_type plan [$];
   int           err_count = 0;
   int           send_idle_pct = 0;
   int           recv_stall_pct = 0;
   bit           csr_busy = 0;
   bit           hold_next = 0;

   task automatic note_error(string what, logic [31:0] got, logic [31:0] due);
      err_count++;
      $display("%0t mismatch %s: got %h want %h", $realtime, what, got, due);
   endtask

   function automatic int eff_rows(logic [15:0] v);
      return (v < 2) ? 2 : int'(v);
   endfunction

   function automatic int eff_cols(logic [10:0] v);
      if (v < 2) return 2;
      if (v > yee2d_pkg::MAX_COLS_DEF) return yee2d_pkg::MAX_COLS_DEF;
      return int'(v);
   endfunction

   // floor(d * c / 2^16)
   function automatic longint scaled(longint d, logic [16:0] c);
      longint cc;
      cc = c;
      return (d * cc) >>> 16;
   endfunction

   function automatic logic signed [31:0] clip(longint v);
      if (v > longint'(FMAX)) return FMAX;
      if (v < longint'(FMIN)) return FMIN;
      return v[31:0];
   endfunction

   function automatic b_word_type curl_step(grid_word_type w);
      int         rows, cols, x, y;
      longint     ez_up, ey_up;
      b_word_type r;
      rows = eff_rows(cfg_rows);
      cols = eff_cols(cfg_cols);
      if (col_at >= cols) begin
         col_at = 0;
         row_at++;
      end
      if (row_at >= rows) row_at = 0;
      x = row_at;
      y = col_at;
      ez_up = longint'(ez_line[y]);
      ey_up = longint'(ey_line[y]);
      r.bx = w.bx;
      r.by = w.by;
      r.bz = w.bz;
      if (x <= rows - 2 && y >= 1 && y <= cols - 2)
         r.bx = clip(longint'(w.bx) - scaled(longint'(w.ez) - longint'(ez_last), cfg_cy));
      if (x >= 1 && x <= rows - 2 && y <= cols - 2)
         r.by = clip(longint'(w.by) + scaled(longint'(w.ez) - ez_up, cfg_cx));
      if (x >= 1 && x <= rows - 2 && y >= 1 && y <= cols - 2)
         r.bz = clip(longint'(w.bz) + scaled(longint'(w.ex) - longint'(ex_last), cfg_cy)
                     - scaled(longint'(w.ey) - ey_up, cfg_cx));
      r.fe = (x == rows - 1) && (y == cols - 1);
      ez_line[y] = w.ez;
      ey_line[y] = w.ey;
      ez_last = w.ez;
      ex_last = w.ex;
      if (y + 1 > ring_hi) ring_hi = y + 1;
      col_at = y + 1;
      if (col_at >= cols) begin
         col_at = 0;
         row_at = x + 1;
         if (row_at >= rows) row_at = 0;
      end
      return r;
   endfunction

   function automatic logic signed [31:0] pick_field();
      int v;
      v = $urandom_range(2097151) - 1048576;
      case ($urandom_range(11))
         0: return FMAX;
         1: return FMIN;
         2: return '0;
         3: return -1;
         4, 5, 6, 7: return $urandom();
         default: return v;
      endcase
   endfunction

   function automatic grid_word_type rand_word();
      grid_word_type w;
      w.ex = pick_field();
      w.ey = pick_field();
      w.ez = pick_field();
      w.bx = pick_field();
      w.by = pick_field();
      w.bz = pick_field();
      return w;
   endfunction

   function automatic int pick_coef();
      case ($urandom_range(7))
         0: return 0;
         1: return 65536;
         2: return 131071;
         3: return 1;
         default: return $urandom_range(65536);
      endcase
   endfunction

   task automatic add_csr(logic [1:0] idx, int val);
      plan_row_type s;
      s.kind = PLAN_CSR;
      s.idx = idx;
      s.data = val;
      plan.push_back(s);
   endtask

   task automatic add_word(logic signed [31:0] ex, ey, ez, bx, by, bz);
      plan_row_type s;
      s.kind = PLAN_WORD;
      s.w = '{ex, ey, ez, bx, by, bz};
      s.typed = 0;
      plan.push_back(s);
   endtask

   // B passes through unchanged on these points
   task automatic add_pass(logic signed [31:0] ex, ey, ez, bx, by, bz, logic fe);
      plan_row_type s;
      s.kind = PLAN_WORD;
      s.w = '{ex, ey, ez, bx, by, bz};
      s.typed = 1;
      s.want = '{bx, by, bz, fe};
      plan.push_back(s);
   endtask

   // only written with the core idle; csr_we stays high across a batch
   task automatic write_csr(logic [1:0] idx, int val);
      if (!csr_busy) begin
         req_ch.valid <= 1'b0;
         while (b_due_q.size() != 0) @(posedge clock);
      end
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val[yee2d_pkg::CSR_DATA_W-1:0];
      csr_busy = 1;
      @(posedge clock);
      case (idx)
         yee2d_pkg::CSR_ROWS_DUAL: cfg_rows = val[15:0];
         yee2d_pkg::CSR_COLS_DUAL: cfg_cols = val[10:0];
         yee2d_pkg::CSR_COEF_X:    cfg_cx = val[16:0];
         yee2d_pkg::CSR_COEF_Y:    cfg_cy = val[16:0];
         default: ;
      endcase
   endtask

   task automatic set_grid(int rows_v, int cols_v, int cx, int cy);
      int r, c, nr, nc;
      nr = eff_rows(rows_v[15:0]);
      nc = eff_cols(cols_v[10:0]);
      r = row_at;
      c = col_at;
      if (c >= nc) begin
         c = 0;
         r++;
      end
      if (r >= nr) r = 0;
      // a wider row mid-frame would read line buffer entries never written
      if (r != 0 && nc > ring_hi) cols_v = ring_hi;
      write_csr(yee2d_pkg::CSR_ROWS_DUAL, rows_v);
      write_csr(yee2d_pkg::CSR_COLS_DUAL, cols_v);
      write_csr(yee2d_pkg::CSR_COEF_X, cx);
      write_csr(yee2d_pkg::CSR_COEF_Y, cy);
   endtask

   task automatic put_word(grid_word_type w, bit typed, b_word_type want);
      b_word_type calc;
      if (csr_busy) begin
         csr_we <= 1'b0;
         csr_busy = 0;
      end
      if (hold_next || $urandom_range(59) == 0) begin
         hold_next = 0;
         while (b_due_q.size() != 0) begin
            req_ch.valid <= 1'b0;
            @(posedge clock);
         end
      end
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.e_x     <= w.ex;
      req_ch.e_y     <= w.ey;
      req_ch.e_z     <= w.ez;
      req_ch.b_x_old <= w.bx;
      req_ch.b_y_old <= w.by;
      req_ch.b_z_old <= w.bz;
      do @(posedge clock); while (!req_ch.ready);
      calc = curl_step(w);
      b_due_q.push_back(typed ? want : calc);
   endtask

   task automatic set_idle(int mode);
      case (mode)
         0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
         1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
         2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
         default: begin send_idle_pct = 33; recv_stall_pct = 33; end
      endcase
   endtask

   always @(posedge clock)
      rsp_ch.ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);

   always @(posedge clock) begin : rsp_check
      b_word_type due;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (b_due_q.size() == 0) begin
            note_error("word with nothing due", rsp_ch.b_x_new, '0);
         end else begin
            due = b_due_q.pop_front();
            if (rsp_ch.b_x_new !== due.bx) note_error("b_x_new", rsp_ch.b_x_new, due.bx);
            if (rsp_ch.b_y_new !== due.by) note_error("b_y_new", rsp_ch.b_y_new, due.by);
            if (rsp_ch.b_z_new !== due.bz) note_error("b_z_new", rsp_ch.b_z_new, due.bz);
            if (rsp_ch.frame_end !== due.fe)
               note_error("frame_end", {31'd0, rsp_ch.frame_end}, {31'd0, due.fe});
         end
      end
   end

   initial begin
      #2_000_000;
      $display("tb: errors");
      $finish;
   end

   initial begin : stim
      b_word_type none;
      int         n, rows_v, cols_v;
      none = '{'0, '0, '0, 1'b0};
      reset          <= 1'b1;
      csr_we         <= 1'b0;
      csr_index      <= yee2d_pkg::CSR_ROWS_DUAL;
      csr_wdata      <= '0;
      req_ch.valid   <= 1'b0;
      req_ch.e_x     <= '0;
      req_ch.e_y     <= '0;
      req_ch.e_z     <= '0;
      req_ch.b_x_old <= '0;
      req_ch.b_y_old <= '0;
      req_ch.b_z_old <= '0;

      // reset grid is 2x2 with zero coefficients: everything passes through
      add_pass(0, 0, 0, FMAX, FMIN, 0, 1'b0);
      add_pass(FMAX, FMIN, FMAX, FMIN, FMAX, -1, 1'b0);
      add_pass(-1, 1, FMIN, 1, -1, FMAX, 1'b0);
      add_pass(FMIN, FMAX, -1, 0, 0, FMIN, 1'b1);
      // 3x3 at unit gain, full-scale differences to saturate both ways
      add_csr(yee2d_pkg::CSR_ROWS_DUAL, 3);
      add_csr(yee2d_pkg::CSR_COLS_DUAL, 3);
      add_csr(yee2d_pkg::CSR_COEF_X, 65536);
      add_csr(yee2d_pkg::CSR_COEF_Y, 65536);
      add_word(FMIN, FMIN, FMIN, 1, 2, 3);
      add_word(FMAX, FMAX, FMAX, FMIN, FMIN, FMIN);
      add_word(0, 0, 0, FMAX, FMAX, FMAX);
      add_word(FMIN, FMIN, FMAX, 0, FMAX, 0);
      add_word(FMAX, FMIN, FMIN, FMAX, FMIN, 0);
      add_word(-1, 1, 32'sh0001_8000, -5, 7, FMIN);
      add_word(32'sh0000_FFFF, -32'sh0001_0000, 32'sh0100_0000, 9, -9, 32'sh0004_0000);
      add_word(FMAX, FMAX, FMIN, -1, -1, -1);
      add_word(FMIN, 0, FMAX, FMAX, FMIN, FMAX);
      // dimensions below range clamp to 2x2
      add_csr(yee2d_pkg::CSR_ROWS_DUAL, 1);
      add_csr(yee2d_pkg::CSR_COLS_DUAL, 0);
      add_pass(FMAX, FMAX, FMAX, 5, 6, 7, 1'b0);
      add_pass(FMIN, FMIN, FMIN, -5, -6, -7, 1'b0);
      add_pass(1, 2, 3, FMAX, FMAX, FMAX, 1'b0);
      add_pass(-1, -2, -3, FMIN, FMIN, FMIN, 1'b1);
      // 4x4 with gain above one, stopped partway through row 1
      add_csr(yee2d_pkg::CSR_ROWS_DUAL, 4);
      add_csr(yee2d_pkg::CSR_COLS_DUAL, 4);
      add_csr(yee2d_pkg::CSR_COEF_X, 131071);
      add_csr(yee2d_pkg::CSR_COEF_Y, 131071);
      add_word(32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000,
               32'sh0010_0000, 32'sh0020_0000, 32'sh0030_0000);
      add_word(-32'sh0000_8001, 32'sh0000_0001, -32'sh0001_2345,
               32'sh0000_1000, -32'sh0000_1000, 32'sh0000_0100);
      add_word(FMAX, -1, FMAX, FMAX, FMIN, -1);
      add_word(0, FMIN, FMIN, 0, 0, 0);
      add_word(32'sh0000_7FFF, 32'sh1234_5678, -32'sh0765_4321, -1, 1, FMAX);
      add_word(FMIN, FMAX, 32'sh0000_0003, 32'sh0000_0005, -32'sh0000_0007, FMIN);
      // shrink mid-frame: column and row both wrap, new frame starts at the origin
      add_csr(yee2d_pkg::CSR_ROWS_DUAL, 2);
      add_csr(yee2d_pkg::CSR_COLS_DUAL, 1);
      add_csr(yee2d_pkg::CSR_COEF_X, 0);
      add_csr(yee2d_pkg::CSR_COEF_Y, 0);
      add_pass(FMAX, 0, FMIN, 11, 22, 33, 1'b0);
      add_pass(0, FMAX, 0, FMIN, FMAX, 0, 1'b0);
      add_pass(FMIN, FMIN, FMAX, -11, -22, -33, 1'b0);
      add_pass(1, -1, 1, FMAX, 0, FMIN, 1'b1);

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         if (plan[i].kind == PLAN_CSR) write_csr(plan[i].idx, plan[i].data);
         else put_word(plan[i].w, plan[i].typed, plan[i].want);
      end

      // widest row, clamped from 2047: half a row at full width
      set_idle(0);
      set_grid(3, 2047, pick_coef(), pick_coef());
      repeat (yee2d_pkg::MAX_COLS_DEF / 2) put_word(rand_word(), 1'b0, none);

      for (int p = 0; p < 12; p++) begin
         set_idle(p % 4);
         case ($urandom_range(11))
            0: rows_v = 65535;
            1: rows_v = $urandom_range(1);
            default: rows_v = $urandom_range(6, 2);
         endcase
         case ($urandom_range(11))
            0: cols_v = $urandom_range(1);
            1: cols_v = 2047;
            2: cols_v = 1024;
            default: cols_v = $urandom_range(10, 2);
         endcase
         set_grid(rows_v, cols_v, pick_coef(), pick_coef());
         if (p == 1) hold_next = 1;
         n = $urandom_range(40, 25);
         repeat (n) put_word(rand_word(), 1'b0, none);
      end

      req_ch.valid <= 1'b0;
      while (b_due_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (err_count == 0)
         $display("tb: clean");
      else
         $display("tb: errors");
      $finish;
   end

endmodule
